// File: src/pmpp_pkg.sv
// Shared types and constants for the packed mono pixel plotter.
// Used by the front, back and top-level modules; depends on nothing.
package pmpp_pkg;

    // Request function codes on the input channel
    localparam logic [1:0] FUNC_SET_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_FILL      = 2'd1;
    localparam logic [1:0] FUNC_READ      = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_OFF_PANEL  = 2'd1;
    localparam logic [1:0] STATUS_PAST_STORE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LANDSCAPE    = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int DIM_W      = 10;
    localparam int COORD_W    = 9;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 14;
    // Widest byte address the tile formula can produce: 8x8 product plus 8 bits
    localparam int PIX_ADDR_W = 17;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 10'd400;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 10'd300;

    // Work kinds handed from the front to the back
    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_FILL,
        OP_READ,
        OP_REPLY
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  bit_pos;
        logic [7:0]  value;
        logic [1:0]  status;
    } cmd_t;

endpackage

// File: src/packed_mono_pixel_plotter.sv
// Top level of the packed mono pixel plotter: front end, command queue and
// back end with the frame store. Uses pmpp_pkg, pmpp_front, pmpp_queue, pmpp_back.
//
// Frame store for a one-bit-per-pixel panel, eight pixels per byte. Requests
// enter through a front end that computes the tile address and classifies them,
// then wait in a two-entry queue for the back end, which owns the store (one
// write and one read port, registered read). Set pixel and read byte
// each take a store read, then a modify-write or capture; requests answered
// from status alone (off panel, past store, unused function) skip the store;
// a fill writes one byte per cycle. The store is not cleared at reset and
// reads as garbage until filled, so issue a fill before drawing. Write the
// configuration only while no request is in flight.
module packed_mono_pixel_plotter import pmpp_pkg::*; #(
    parameter int FRAME_BYTES = 16384
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic [COORD_W-1:0]    s_x,
    input  logic [COORD_W-1:0]    s_y,
    input  logic [BYTE_W-1:0]     s_value,
    input  logic [INDEX_W-1:0]    s_byte_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_read_data,
    output logic [1:0]            m_status
);

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam int CMD_W  = $bits(cmd_t);
    localparam int Q_W    = ADDR_W + CMD_W;

    logic              fe_push;
    cmd_t              fe_cmd;
    logic [ADDR_W-1:0] fe_addr;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic [Q_W-1:0]    q_word;
    cmd_t              be_cmd;
    logic [ADDR_W-1:0] be_addr;

    pmpp_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_x          (s_x),
        .s_y          (s_y),
        .s_value      (s_value),
        .s_byte_index (s_byte_index),
        .q_push       (fe_push),
        .q_cmd        (fe_cmd),
        .q_addr       (fe_addr),
        .q_full       (q_full)
    );

    pmpp_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fe_push),
        .wr_data ({fe_addr, fe_cmd}),
        .pop     (q_pop),
        .rd_data (q_word),
        .empty   (q_empty),
        .full    (q_full)
    );

    assign be_cmd  = cmd_t'(q_word[CMD_W-1:0]);
    assign be_addr = q_word[Q_W-1:CMD_W];

    pmpp_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (!q_empty),
        .q_cmd       (be_cmd),
        .q_addr      (be_addr),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_status    (m_status)
    );

endmodule

// File: src/pmpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the frame store.
module pmpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // Hold the last read word while no read is issued
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pmpp_queue.sv
// Small register FIFO between the front and the back.
// Standalone; carries packed command words.
module pmpp_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count past depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue popped while empty");
`endif

endmodule

// File: src/pmpp_front.sv
// Front end: configuration registers, request intake, tile address math
// and classification into commands for the back end. Uses pmpp_pkg.
module pmpp_front import pmpp_pkg::*; #(
    parameter int FRAME_BYTES = 16384
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [COORD_W-1:0]             s_x,
    input  logic [COORD_W-1:0]             s_y,
    input  logic [BYTE_W-1:0]              s_value,
    input  logic [INDEX_W-1:0]             s_byte_index,
    output logic                           q_push,
    output cmd_t                           q_cmd,
    output logic [$clog2(FRAME_BYTES)-1:0] q_addr,
    input  logic                           q_full
);

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam logic [PIX_ADDR_W-1:0] STORE_LIMIT = PIX_ADDR_W'(FRAME_BYTES);

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic             landscape_reg;

    logic                  stg_valid_reg;
    logic [1:0]            stg_func_reg;
    logic [PIX_ADDR_W-1:0] stg_addr_reg;
    logic [2:0]            stg_bit_reg;
    logic [BYTE_W-1:0]     stg_value_reg;
    logic                  stg_off_reg;
    logic [INDEX_W-1:0]    stg_index_reg;

    logic                  s_accept;
    logic                  off_panel;
    logic [DIM_W-1:0]      flip_y;
    logic [7:0]            major;
    logic [7:0]            stride;
    logic [7:0]            minor;
    logic [2:0]            tile_pos;
    logic [15:0]           product;
    logic [PIX_ADDR_W-1:0] pix_addr;
    logic [PIX_ADDR_W-1:0] index_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            landscape_reg    <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                CFG_LANDSCAPE:    landscape_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_ready  = !stg_valid_reg || !q_full;
    assign s_accept = s_valid && s_ready;
    assign q_push   = stg_valid_reg && !q_full;

    // Tile address: major * tiles-per-line + minor, bit counted from the MSB
    always_comb begin
        off_panel = ({1'b0, s_x} >= frame_width_reg) || ({1'b0, s_y} >= frame_height_reg);
        flip_y    = frame_height_reg - 10'd1 - {1'b0, s_y};
        if (landscape_reg) begin
            major    = s_x[8:1];
            stride   = frame_height_reg[9:2];
            minor    = flip_y[9:2];
            tile_pos = {flip_y[1:0], s_x[0]};
        end else begin
            major    = s_y[8:1];
            stride   = frame_width_reg[9:2];
            minor    = {1'b0, s_x[8:2]};
            tile_pos = {s_x[1:0], s_y[0]};
        end
        product  = major * stride;
        pix_addr = {1'b0, product} + {9'd0, minor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_accept) begin
            stg_valid_reg <= 1'b1;
        end else if (q_push) begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stg_func_reg  <= s_func;
            stg_addr_reg  <= pix_addr;
            stg_bit_reg   <= 3'd7 - tile_pos;
            stg_value_reg <= s_value;
            stg_off_reg   <= off_panel;
            stg_index_reg <= s_byte_index;
        end
    end

    // Classify the staged request
    always_comb begin
        index_ext     = {{(PIX_ADDR_W - INDEX_W){1'b0}}, stg_index_reg};
        q_cmd.bit_pos = stg_bit_reg;
        q_cmd.value   = stg_value_reg;
        q_cmd.status  = STATUS_OK;
        q_cmd.op      = OP_REPLY;
        q_addr        = stg_addr_reg[ADDR_W-1:0];
        unique case (stg_func_reg)
            FUNC_SET_PIXEL: begin
                if (stg_off_reg) begin
                    q_cmd.status = STATUS_OFF_PANEL;
                end else if (stg_addr_reg >= STORE_LIMIT) begin
                    q_cmd.status = STATUS_PAST_STORE;
                end else begin
                    q_cmd.op = OP_PIXEL;
                end
            end
            FUNC_FILL: begin
                q_cmd.op = OP_FILL;
            end
            FUNC_READ: begin
                q_addr = index_ext[ADDR_W-1:0];
                if (index_ext >= STORE_LIMIT) begin
                    q_cmd.status = STATUS_PAST_STORE;
                end else begin
                    q_cmd.op = OP_READ;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: src/pmpp_back.sv
// Back end: executes commands against the frame store (pixel read-modify-
// write, fill sweep, byte read) and holds the result register. Uses
// pmpp_pkg and pmpp_ram.
module pmpp_back import pmpp_pkg::*; #(
    parameter int FRAME_BYTES = 16384
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  cmd_t                           q_cmd,
    input  logic [$clog2(FRAME_BYTES)-1:0] q_addr,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [BYTE_W-1:0]              m_read_data,
    output logic [1:0]                     m_status
);

    localparam int ADDR_W = $clog2(FRAME_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIXEL,
        S_READ,
        S_FILL,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        bit_reg;
    logic [BYTE_W-1:0] value_reg;
    logic [ADDR_W-1:0] fill_cnt_reg;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic [1:0]        m_status_reg;

    logic              out_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] mask;
    logic              res_load;
    logic [BYTE_W-1:0] res_data;
    logic [1:0]        res_status;

    pmpp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign mask     = 8'b1 << bit_reg;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = (value_reg != '0) ? (ram_rdata | mask) : (ram_rdata & ~mask);
        res_load   = 1'b0;
        res_data   = '0;
        res_status = STATUS_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.op)
                        OP_PIXEL: begin
                            q_pop      = 1'b1;
                            ram_re     = 1'b1;
                            state_next = S_PIXEL;
                        end
                        OP_READ: begin
                            q_pop      = 1'b1;
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                        OP_FILL: begin
                            q_pop      = 1'b1;
                            state_next = S_FILL;
                        end
                        OP_REPLY: begin
                            // Status-only request: answer straight away once the result register is free
                            if (out_free) begin
                                q_pop      = 1'b1;
                                res_load   = 1'b1;
                                res_status = q_cmd.status;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PIXEL: begin
                // Hold the read word until the result register frees up
                if (out_free) begin
                    ram_we     = 1'b1;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    res_data   = ram_rdata;
                    state_next = S_IDLE;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = fill_cnt_reg;
                ram_wdata = value_reg;
                if (fill_cnt_reg == LAST_ADDR) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (res_load) begin
                m_valid_reg  <= 1'b1;
                m_data_reg   <= res_data;
                m_status_reg <= res_status;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                addr_reg     <= q_addr;
                bit_reg      <= q_cmd.bit_pos;
                value_reg    <= q_cmd.value;
                fill_cnt_reg <= '0;
            end else if (state_reg == S_FILL) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;
    assign m_status    = m_status_reg;

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("store read and write in the same cycle");
    a_pixel_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PIXEL && $past(state_reg) == S_IDLE) |-> $past(ram_re))
        else $error("pixel modify without a preceding store read");
    a_fill_from_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL && $past(state_reg) == S_IDLE) |-> fill_cnt_reg == '0)
        else $error("fill sweep did not start at address zero");
`endif

endmodule
